>>> design/kvs_pkg.sv
package kvs_pkg;

   localparam int unsigned DIV_W = 32;

   localparam logic [7:0]  NOTE_BASE  = 8'd69;
   localparam logic [7:0]  POLL_LIMIT = 8'd20;
   localparam int unsigned ROW_SHIFT  = 4;
   localparam logic [15:0] MASK_RESET = 16'h01F0;

   localparam logic [2:0] REG_CLEAN_UP   = 3'd0;
   localparam logic [2:0] REG_RETRIGGER  = 3'd1;
   localparam logic [2:0] REG_MIN_IVAL   = 3'd2;
   localparam logic [2:0] REG_MAX_IVAL   = 3'd3;
   localparam logic [2:0] REG_VEL_SCALE  = 3'd4;
   localparam logic [2:0] REG_VEL_BASE   = 3'd5;

   localparam logic KIND_HIT  = 1'b0;
   localparam logic KIND_POLL = 1'b1;

   localparam logic [1:0] STAGE_IDLE  = 2'd0;
   localparam logic [1:0] STAGE_ARMED = 2'd1;
   localparam logic [1:0] STAGE_DONE  = 2'd2;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [DIV_W-1:0] remainder;
   } div_rsp_type;

endpackage

>>> design/kvs_divider.sv
module kvs_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  kvs_pkg::div_req_type div_req,
   output kvs_pkg::div_rsp_type div_rsp
);
   import kvs_pkg::*;

   localparam int unsigned CNT_W = $clog2(DIV_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_W - 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [DIV_W-1:0] dvs_ff;
   logic [DIV_W:0]   shifted;
   logic             fits;

   // one restoring step per cycle
   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start && !busy_ff) begin
         quo_ff <= div_req.dividend;
         rem_ff <= '0;
         dvs_ff <= div_req.divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= DIV_W'(shifted - {1'b0, dvs_ff});
         end else begin
            rem_ff <= shifted[DIV_W-1:0];
         end
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

>>> design/key_velocity_sensor_timing_core.sv
// Key velocity timing core for a two-sensor keyboard scanner.
// Requests enter on start/req_* and are taken when start is high and busy is
// low. req_kind selects a sensor hit or a scan pass poll. Each request gives
// exactly one result on rsp_*, shown for one cycle with rsp_strobe high; the
// receiver cannot stall, so the result is simply presented once.
// A hit that gives no note passes through the hit steps to the output step;
// a hit that gives a note also runs the shared 32-bit divider twice
// (scale / interval, then velocity / base) at one quotient bit a cycle.
// A poll on an empty queue goes straight to its end step; otherwise it also
// does the queue read and the sensor memory read. busy stays high from
// acceptance until the result strobe, so one request is in flight at a time.
// Sensor stamps and stages sit in one memory with a valid bit per slot,
// cleared at once by reset, so no clearing pass is needed. The pending queue
// is a plain memory with head, tail and count.
// Registers are written on csr_* whenever csr_valid is high (csr_ready is
// always high); write them only while no request is in flight.
// reset is synchronous and active high; it restores register defaults,
// row masks, the queue pointers and the counters.
module key_velocity_sensor_timing_core #(
   parameter int unsigned MUX_ROWS     = 16,
   parameter int unsigned SENSOR_SLOTS = 256,
   parameter int unsigned QUEUE_DEPTH  = 64,
   parameter int unsigned TIME_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [3:0]  req_channel,
   input  logic [3:0]  req_mux_row,
   input  logic [31:0] req_timestamp,
   output logic        rsp_strobe,
   output logic        rsp_note_valid,
   output logic [7:0]  rsp_note,
   output logic [31:0] rsp_velocity,
   output logic [31:0] rsp_velocity_high,
   output logic [15:0] rsp_velocity_low,
   output logic        rsp_released_valid,
   output logic [7:0]  rsp_released_index,
   output logic        rsp_report_ready,
   output logic        rsp_queue_overflow,
   output logic [15:0] rsp_enable_mask,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import kvs_pkg::*;

   localparam int unsigned SW    = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
   localparam int unsigned RW    = (MUX_ROWS > 1) ? $clog2(MUX_ROWS) : 1;
   localparam int unsigned QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned ENT_W = TIME_BITS + 2;
   localparam logic [SW-1:0] SLOT_LAST  = SW'(SENSOR_SLOTS - 1);
   localparam logic [QW-1:0] QUEUE_LAST = QW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] QUEUE_FULL = CW'(QUEUE_DEPTH);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_HIT0     = 4'd1;
   localparam logic [3:0] S_HIT1     = 4'd2;
   localparam logic [3:0] S_HIT2     = 4'd3;
   localparam logic [3:0] S_HIT3     = 4'd4;
   localparam logic [3:0] S_HIT_UP   = 4'd5;
   localparam logic [3:0] S_DIV1     = 4'd6;
   localparam logic [3:0] S_DIV2     = 4'd7;
   localparam logic [3:0] S_POLL0    = 4'd8;
   localparam logic [3:0] S_POLL1    = 4'd9;
   localparam logic [3:0] S_POLL2    = 4'd10;
   localparam logic [3:0] S_POLL3    = 4'd11;
   localparam logic [3:0] S_POLL_END = 4'd12;
   localparam logic [3:0] S_OUT      = 4'd13;

   // reduce a small index modulo m by restoring subtraction
   function automatic logic [7:0] mod_small(input logic [7:0] v, input int unsigned m);
      logic [16:0] r;
      logic [16:0] t;
      r = 17'(v);
      for (int k = 7; k >= 0; k--) begin
         t = 17'(m) << k;
         if (r >= t) begin
            r = r - t;
         end
      end
      return r[7:0];
   endfunction

   // configuration
   logic [31:0] clean_up_ff, retrig_ff, min_ival_ff, max_ival_ff, scale_ff;
   logic [15:0] base_ff;

   // sequencer and request hold
   logic [3:0]           state_ff, state_in;
   logic                 kind_ff;
   logic [3:0]           chan_ff;
   logic [RW-1:0]        row_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [SW-1:0]        slot_ff;
   logic [1:0]           stage_s_ff;
   logic [ENT_W-1:0]     ent_n_ff;
   logic [TIME_BITS-1:0] gap_ff;
   logic [SW-1:0]        pslot_ff;
   logic [7:0]           pidx_ff;

   // sensor memory
   logic [ENT_W-1:0]        sensor_ram [SENSOR_SLOTS];
   logic [SENSOR_SLOTS-1:0] slot_valid_ff;
   logic [ENT_W-1:0]        ram_rd_ff;
   logic                    ram_rdv_ff;
   logic [SW-1:0]           ram_raddr;
   logic                    ram_we;
   logic [SW-1:0]           ram_waddr;
   logic [ENT_W-1:0]        ram_wdata;
   logic [ENT_W-1:0]        entry;

   // pending queue
   logic [7:0]    fifo_ram [QUEUE_DEPTH];
   logic [7:0]    fifo_rd_ff;
   logic [QW-1:0] head_ff, tail_ff;
   logic [CW-1:0] count_ff;

   logic [15:0] masks_ff [MUX_ROWS];
   logic [7:0]  poll_count_ff;
   logic [15:0] event_count_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [RW-1:0]        req_row;
   logic [7:0]           req_idx;
   logic [SW-1:0]        lower_slot, upper_slot;
   logic [SW-1:0]        fifo_slot;
   logic [RW-1:0]        rel_row;
   logic [RW-1:0]        mask_addr;
   logic [15:0]          mask_cur;
   logic [TIME_BITS-1:0] ent_stamp;
   logic                 odd_row;
   logic [31:0]          gap_wide;
   logic [15:0]          base_eff;
   logic [7:0]           poll_next;
   logic [7:0]           slot8;

   kvs_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign req_row    = RW'(mod_small({4'b0000, req_mux_row}, MUX_ROWS));
   assign req_idx    = {req_channel, 4'(req_row)};
   assign lower_slot = (slot_ff == '0) ? SLOT_LAST : slot_ff - 1'b1;
   assign upper_slot = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
   assign fifo_slot  = SW'(mod_small(fifo_rd_ff, SENSOR_SLOTS));
   assign rel_row    = RW'(mod_small({4'b0000, pidx_ff[3:0]}, MUX_ROWS));
   assign odd_row    = row_ff[0];
   assign entry      = ram_rdv_ff ? ram_rd_ff : '0;
   assign ent_stamp  = entry[TIME_BITS-1:0];
   assign gap_wide   = 32'(gap_ff);
   assign base_eff   = (base_ff == '0) ? 16'd1 : base_ff;
   assign poll_next  = (poll_count_ff == 8'hFF) ? poll_count_ff : poll_count_ff + 1'b1;
   assign slot8      = 8'(slot_ff);
   assign mask_addr  = (state_ff == S_POLL3) ? rel_row : row_ff;
   assign mask_cur   = masks_ff[mask_addr];

   // configuration write port
   always_ff @(posedge clock) begin
      if (reset) begin
         clean_up_ff <= 32'd50000;
         retrig_ff   <= 32'd1000;
         min_ival_ff <= 32'd200;
         max_ival_ff <= 32'd50000;
         scale_ff    <= 32'd10000000;
         base_ff     <= 16'd128;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_CLEAN_UP:  clean_up_ff <= csr_data;
            REG_RETRIGGER: retrig_ff   <= csr_data;
            REG_MIN_IVAL:  min_ival_ff <= csr_data;
            REG_MAX_IVAL:  max_ival_ff <= csr_data;
            REG_VEL_SCALE: scale_ff    <= csr_data;
            REG_VEL_BASE:  base_ff     <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // sensor memory read address by step
   always_comb begin
      case (state_ff)
         S_HIT0:  ram_raddr = slot_ff;
         S_HIT1:  ram_raddr = odd_row ? lower_slot : upper_slot;
         S_POLL1: ram_raddr = fifo_slot;
         default: ram_raddr = slot_ff;
      endcase
   end

   // sensor memory writes: arm, stamp, mark done, release
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = slot_ff;
      ram_wdata = {stage_s_ff, now_ff};
      case (state_ff)
         S_HIT3: begin
            if (odd_row) begin
               if (stage_s_ff == STAGE_IDLE && gap_wide > retrig_ff) begin
                  ram_we    = 1'b1;
                  ram_wdata = {STAGE_ARMED, now_ff};
               end
            end else if (ent_n_ff[ENT_W-1:TIME_BITS] == STAGE_ARMED &&
                         gap_wide > min_ival_ff && gap_wide < max_ival_ff) begin
               ram_we = 1'b1;
            end
         end
         S_HIT_UP: begin
            ram_we    = 1'b1;
            ram_waddr = upper_slot;
            ram_wdata = {STAGE_DONE, ent_n_ff[TIME_BITS-1:0]};
         end
         S_POLL3: begin
            ram_waddr = pslot_ff;
            ram_wdata = {STAGE_IDLE, ent_n_ff[TIME_BITS-1:0]};
            ram_we    = gap_wide > clean_up_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         sensor_ram[ram_waddr] <= ram_wdata;
      end
      ram_rd_ff <= sensor_ram[ram_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         ram_rdv_ff    <= 1'b0;
      end else begin
         ram_rdv_ff <= slot_valid_ff[ram_raddr];
         if (ram_we) begin
            slot_valid_ff[ram_waddr] <= 1'b1;
         end
      end
   end

   // divider requests: interval first, then the base split
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = scale_ff;
      div_req.divisor  = gap_wide;
      if (state_ff == S_HIT_UP) begin
         div_req.start = 1'b1;
      end else if (state_ff == S_DIV1 && div_rsp.done) begin
         div_req.start    = 1'b1;
         div_req.dividend = div_rsp.quotient;
         div_req.divisor  = 32'(base_eff);
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = (req_kind == KIND_HIT) ? S_HIT0 : S_POLL0;
            end
         end
         S_HIT0: state_in = S_HIT1;
         S_HIT1: state_in = S_HIT2;
         S_HIT2: state_in = S_HIT3;
         S_HIT3: state_in = (!odd_row && ram_we) ? S_HIT_UP : S_OUT;
         S_HIT_UP: state_in = S_DIV1;
         S_DIV1: begin
            if (div_rsp.done) begin
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_rsp.done) begin
               state_in = S_OUT;
            end
         end
         S_POLL0: state_in = (count_ff != '0) ? S_POLL1 : S_POLL_END;
         S_POLL1: state_in = S_POLL2;
         S_POLL2: state_in = S_POLL3;
         S_POLL3: state_in = S_POLL_END;
         S_POLL_END: state_in = S_OUT;
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control state: sequencer, queue pointers, masks, counters, strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         poll_count_ff  <= '0;
         event_count_ff <= '0;
         rsp_strobe     <= 1'b0;
         for (int i = 0; i < MUX_ROWS; i++) begin
            masks_ff[i] <= MASK_RESET;
         end
      end else begin
         state_ff   <= state_in;
         rsp_strobe <= (state_ff == S_OUT);
         case (state_ff)
            S_HIT0: begin
               // mask the sensor and queue it unless the queue is full
               masks_ff[mask_addr] <= mask_cur & ~(16'd1 << chan_ff);
               if (count_ff != QUEUE_FULL) begin
                  tail_ff  <= (tail_ff == QUEUE_LAST) ? '0 : tail_ff + 1'b1;
                  count_ff <= count_ff + 1'b1;
               end
            end
            S_DIV2: begin
               if (div_rsp.done && event_count_ff != 16'hFFFF) begin
                  event_count_ff <= event_count_ff + 1'b1;
               end
            end
            S_POLL3: begin
               if (ram_we) begin
                  masks_ff[mask_addr] <= mask_cur | (16'd1 << pidx_ff[7:ROW_SHIFT]);
                  head_ff  <= (head_ff == QUEUE_LAST) ? '0 : head_ff + 1'b1;
                  count_ff <= count_ff - 1'b1;
               end
            end
            S_POLL_END: begin
               if (event_count_ff != '0 && poll_next > POLL_LIMIT) begin
                  poll_count_ff  <= '0;
                  event_count_ff <= '0;
               end else begin
                  poll_count_ff <= poll_next;
               end
            end
            default: ;
         endcase
      end
   end

   // queue memory
   always_ff @(posedge clock) begin
      if (state_ff == S_HIT0 && count_ff != QUEUE_FULL) begin
         fifo_ram[tail_ff] <= {chan_ff, 4'(row_ff)};
      end
      fifo_rd_ff <= fifo_ram[head_ff];
   end

   // payload: request hold, intermediates and result fields
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_ff            <= req_kind;
               chan_ff            <= req_channel;
               row_ff             <= req_row;
               now_ff             <= req_timestamp[TIME_BITS-1:0];
               slot_ff            <= SW'(mod_small(req_idx, SENSOR_SLOTS));
               rsp_note_valid     <= 1'b0;
               rsp_note           <= '0;
               rsp_velocity       <= '0;
               rsp_velocity_high  <= '0;
               rsp_velocity_low   <= '0;
               rsp_released_valid <= 1'b0;
               rsp_released_index <= '0;
               rsp_report_ready   <= 1'b0;
               rsp_queue_overflow <= 1'b0;
            end
         end
         S_HIT0: rsp_queue_overflow <= (count_ff == QUEUE_FULL);
         S_HIT1: stage_s_ff <= entry[ENT_W-1:TIME_BITS];
         S_HIT2: begin
            ent_n_ff <= entry;
            gap_ff   <= now_ff - ent_stamp;
         end
         S_DIV1: begin
            if (div_rsp.done) begin
               rsp_velocity <= div_rsp.quotient;
            end
         end
         S_DIV2: begin
            if (div_rsp.done) begin
               rsp_note_valid    <= 1'b1;
               rsp_note          <= NOTE_BASE + {1'b0, slot8[7:1]};
               rsp_velocity_high <= div_rsp.quotient;
               rsp_velocity_low  <= div_rsp.remainder[15:0];
            end
         end
         S_POLL1: begin
            pslot_ff <= fifo_slot;
            pidx_ff  <= fifo_rd_ff;
         end
         S_POLL2: begin
            ent_n_ff <= entry;
            gap_ff   <= now_ff - ent_stamp;
         end
         S_POLL3: begin
            if (ram_we) begin
               rsp_released_valid <= 1'b1;
               rsp_released_index <= pidx_ff;
            end
         end
         S_POLL_END: begin
            rsp_report_ready <= (event_count_ff != '0 && poll_next > POLL_LIMIT);
         end
         S_OUT: rsp_enable_mask <= mask_cur;
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(state_ff == S_OUT)))
      else $error("result strobe outside the output step");

   a_note_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_note_valid) |-> (kind_ff == KIND_HIT && !rsp_released_valid))
      else $error("note reported on a poll");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_FULL)
      else $error("queue count beyond depth");
`endif

endmodule
